>>> rtl/aqit_pkg.sv
// Package for the air quality index tracker: codes, reciprocals and sub-index functions.
`timescale 1ns / 1ps

package aqit_pkg;

  // Default number of fractional bits of the smoothed index
  localparam int unsigned AQIT_FRAC_BITS_DEF = 8;

  // Register fields and sub-index width
  localparam int unsigned CFG_W   = 9;
  localparam int unsigned CFG_AW  = 2;
  localparam int unsigned INDEX_W = 9;
  localparam int unsigned BAND_W  = 2;
  localparam int unsigned NUM_W   = 17;
  localparam int unsigned RCP_W   = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_AW-1:0] CFG_SMOOTH_FLOOR    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_BAND_LIMIT_LOW  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_BAND_LIMIT_MID  = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_BAND_LIMIT_HIGH = 2'd3;

  // Register reset values
  localparam logic [CFG_W-1:0] SMOOTH_FLOOR_RST    = 9'd10;
  localparam logic [CFG_W-1:0] BAND_LIMIT_LOW_RST  = 9'd50;
  localparam logic [CFG_W-1:0] BAND_LIMIT_MID_RST  = 9'd100;
  localparam logic [CFG_W-1:0] BAND_LIMIT_HIGH_RST = 9'd200;

  // Band codes
  localparam logic [BAND_W-1:0] BAND_GOOD     = 2'd0;
  localparam logic [BAND_W-1:0] BAND_MODERATE = 2'd1;
  localparam logic [BAND_W-1:0] BAND_POOR     = 2'd2;
  localparam logic [BAND_W-1:0] BAND_BAD      = 2'd3;

  // Top of the index scale
  localparam logic [INDEX_W-1:0] INDEX_MAX = 9'd500;

  // Pollutant codes
  typedef enum logic [2:0] {
    POL_ECO2 = 3'd0,
    POL_TVOC = 3'd1,
    POL_PM25 = 3'd2,
    POL_PM10 = 3'd3,
    POL_CO   = 3'd4
  } pollutant_t;

  // Reciprocals ceil(2^31 / d); exact floor for every numerator a segment can produce
  localparam int unsigned RCP_SHIFT = 31;
  localparam logic [63:0] RCP_ONE   = 64'd1 << RCP_SHIFT;

  localparam logic [RCP_W-1:0] RCP_1    = 32'((RCP_ONE + 64'd0) / 64'd1);
  localparam logic [RCP_W-1:0] RCP_2    = 32'((RCP_ONE + 64'd1) / 64'd2);
  localparam logic [RCP_W-1:0] RCP_4    = 32'((RCP_ONE + 64'd3) / 64'd4);
  localparam logic [RCP_W-1:0] RCP_5    = 32'((RCP_ONE + 64'd4) / 64'd5);
  localparam logic [RCP_W-1:0] RCP_6    = 32'((RCP_ONE + 64'd5) / 64'd6);
  localparam logic [RCP_W-1:0] RCP_7    = 32'((RCP_ONE + 64'd6) / 64'd7);
  localparam logic [RCP_W-1:0] RCP_9    = 32'((RCP_ONE + 64'd8) / 64'd9);
  localparam logic [RCP_W-1:0] RCP_10   = 32'((RCP_ONE + 64'd9) / 64'd10);
  localparam logic [RCP_W-1:0] RCP_15   = 32'((RCP_ONE + 64'd14) / 64'd15);
  localparam logic [RCP_W-1:0] RCP_19   = 32'((RCP_ONE + 64'd18) / 64'd19);
  localparam logic [RCP_W-1:0] RCP_24   = 32'((RCP_ONE + 64'd23) / 64'd24);
  localparam logic [RCP_W-1:0] RCP_40   = 32'((RCP_ONE + 64'd39) / 64'd40);
  localparam logic [RCP_W-1:0] RCP_47   = 32'((RCP_ONE + 64'd46) / 64'd47);
  localparam logic [RCP_W-1:0] RCP_85   = 32'((RCP_ONE + 64'd84) / 64'd85);
  localparam logic [RCP_W-1:0] RCP_108  = 32'((RCP_ONE + 64'd107) / 64'd108);
  localparam logic [RCP_W-1:0] RCP_577  = 32'((RCP_ONE + 64'd576) / 64'd577);
  localparam logic [RCP_W-1:0] RCP_898  = 32'((RCP_ONE + 64'd897) / 64'd898);
  localparam logic [RCP_W-1:0] RCP_1052 = 32'((RCP_ONE + 64'd1051) / 64'd1052);
  localparam logic [RCP_W-1:0] RCP_1308 = 32'((RCP_ONE + 64'd1307) / 64'd1308);
  localparam logic [RCP_W-1:0] RCP_1576 = 32'((RCP_ONE + 64'd1575) / 64'd1576);

  // Evaluate one segment: floor(num / d) + ofs through the reciprocal of d
  function automatic logic [INDEX_W-1:0] seg_eval(input logic [NUM_W-1:0] num,
                                                  input logic [RCP_W-1:0] rcp,
                                                  input logic [INDEX_W-1:0] ofs);
    logic [NUM_W+RCP_W-1:0] prod;
    logic [INDEX_W-1:0]     quot;
    prod = {{RCP_W{1'b0}}, num} * {{NUM_W{1'b0}}, rcp};
    quot = INDEX_W'(prod >> RCP_SHIFT);
    return quot + ofs;
  endfunction

  // eCO2 sub-index
  function automatic logic [INDEX_W-1:0] sub_eco2(input logic [15:0] e);
    logic [23:0]        ex;
    logic [NUM_W-1:0]   num;
    logic [RCP_W-1:0]   rcp;
    logic [INDEX_W-1:0] ofs;
    ex = 24'(e);
    priority if (e < 16'd350) begin
      num = '0; rcp = RCP_1; ofs = '0;
    end else if (e <= 16'd884) begin
      num = NUM_W'((ex - 24'd350) * 24'd100); rcp = RCP_1052; ofs = 9'd0;
    end else if (e <= 16'd1333) begin
      num = NUM_W'(ex * 24'd100 - 24'd88498); rcp = RCP_898; ofs = 9'd51;
    end else if (e <= 16'd1765) begin
      num = NUM_W'(ex * 24'd10 - 24'd13335); rcp = RCP_85; ofs = 9'd101;
    end else if (e <= 16'd2551) begin
      num = NUM_W'(ex * 24'd100 - 24'd176576); rcp = RCP_1576; ofs = 9'd151;
    end else if (e <= 16'd3851) begin
      num = NUM_W'(ex * 24'd100 - 24'd255108); rcp = RCP_1308; ofs = 9'd201;
    end else if (e < 16'd5000) begin
      num = NUM_W'(ex * 24'd100 - 24'd385177); rcp = RCP_577; ofs = 9'd301;
    end else begin
      num = '0; rcp = RCP_1; ofs = INDEX_MAX;
    end
    return seg_eval(num, rcp, ofs);
  endfunction

  // TVOC sub-index
  function automatic logic [INDEX_W-1:0] sub_tvoc(input logic [15:0] t);
    logic [NUM_W-1:0]   tx;
    logic [NUM_W-1:0]   num;
    logic [RCP_W-1:0]   rcp;
    logic [INDEX_W-1:0] ofs;
    tx = NUM_W'(t);
    priority if (t < 16'd300) begin
      num = tx; rcp = RCP_6; ofs = 9'd0;
    end else if (t < 16'd500) begin
      num = tx - 17'd300; rcp = RCP_4; ofs = 9'd50;
    end else if (t < 16'd1000) begin
      num = tx - 17'd500; rcp = RCP_10; ofs = 9'd100;
    end else if (t < 16'd3000) begin
      num = tx - 17'd1000; rcp = RCP_40; ofs = 9'd150;
    end else if (t < 16'd4000) begin
      num = tx - 17'd3000; rcp = RCP_10; ofs = 9'd200;
    end else if (t < 16'd5000) begin
      num = tx - 17'd4000; rcp = RCP_5; ofs = 9'd300;
    end else begin
      num = '0; rcp = RCP_1; ofs = INDEX_MAX;
    end
    return seg_eval(num, rcp, ofs);
  endfunction

  // PM2.5 sub-index
  function automatic logic [INDEX_W-1:0] sub_pm25(input logic [11:0] p);
    logic [NUM_W-1:0]   px;
    logic [NUM_W-1:0]   num;
    logic [RCP_W-1:0]   rcp;
    logic [INDEX_W-1:0] ofs;
    px = NUM_W'(p);
    priority if (p <= 12'd12) begin
      num = px * 17'd100; rcp = RCP_24; ofs = 9'd0;
    end else if (p <= 12'd35) begin
      num = px * 17'd100 - 17'd1210; rcp = RCP_47; ofs = 9'd51;
    end else if (p <= 12'd55) begin
      num = px * 17'd10 - 17'd355; rcp = RCP_4; ofs = 9'd101;
    end else if (p <= 12'd150) begin
      num = px * 17'd10 - 17'd555; rcp = RCP_19; ofs = 9'd151;
    end else if (p <= 12'd250) begin
      num = px; rcp = RCP_1; ofs = 9'd50;
    end else if (p <= 12'd500) begin
      num = px * 17'd4 - 17'd1002; rcp = RCP_5; ofs = 9'd301;
    end else begin
      num = '0; rcp = RCP_1; ofs = INDEX_MAX;
    end
    return seg_eval(num, rcp, ofs);
  endfunction

  // PM10 sub-index
  function automatic logic [INDEX_W-1:0] sub_pm10(input logic [11:0] q);
    logic [NUM_W-1:0]   qx;
    logic [NUM_W-1:0]   num;
    logic [RCP_W-1:0]   rcp;
    logic [INDEX_W-1:0] ofs;
    qx = NUM_W'(q);
    priority if (q < 12'd55) begin
      num = qx * 17'd100; rcp = RCP_108; ofs = 9'd0;
    end else if (q < 12'd155) begin
      num = qx - 17'd55; rcp = RCP_2; ofs = 9'd51;
    end else if (q < 12'd255) begin
      num = qx - 17'd155; rcp = RCP_2; ofs = 9'd101;
    end else if (q < 12'd355) begin
      num = qx - 17'd255; rcp = RCP_2; ofs = 9'd151;
    end else if (q < 12'd425) begin
      num = (qx - 17'd355) * 17'd10; rcp = RCP_7; ofs = 9'd201;
    end else if (q < 12'd604) begin
      num = (qx - 17'd425) * 17'd10; rcp = RCP_9; ofs = 9'd301;
    end else begin
      num = '0; rcp = RCP_1; ofs = INDEX_MAX;
    end
    return seg_eval(num, rcp, ofs);
  endfunction

  // CO sub-index
  function automatic logic [INDEX_W-1:0] sub_co(input logic [15:0] c);
    logic [NUM_W-1:0]   cx;
    logic [NUM_W-1:0]   num;
    logic [RCP_W-1:0]   rcp;
    logic [INDEX_W-1:0] ofs;
    cx = NUM_W'(c);
    priority if (c < 16'd450) begin
      num = cx; rcp = RCP_9; ofs = 9'd0;
    end else if (c < 16'd950) begin
      num = cx - 17'd450; rcp = RCP_10; ofs = 9'd51;
    end else if (c < 16'd1250) begin
      num = cx - 17'd950; rcp = RCP_6; ofs = 9'd101;
    end else if (c < 16'd1550) begin
      num = cx - 17'd1250; rcp = RCP_6; ofs = 9'd151;
    end else if (c < 16'd3050) begin
      num = cx - 17'd1550; rcp = RCP_15; ofs = 9'd201;
    end else if (c < 16'd5040) begin
      num = cx - 17'd3050; rcp = RCP_10; ofs = 9'd301;
    end else begin
      num = '0; rcp = RCP_1; ofs = INDEX_MAX;
    end
    return seg_eval(num, rcp, ofs);
  endfunction

endpackage

>>> rtl/air_quality_index_tracker.sv
// Air quality index tracker: sub-indices, dominant pollutant, smoothing and banding.
//
//   channel | direction | handshake                  | payload
//   in_     | slave     | in_tvalid / in_tready      | in_tdata readings, in_tuser pm_ready
//   out_    | master    | out_tvalid / out_tready    | out_tdata index/smoothed/band, out_tuser
//   cfg_    | write     | cfg_we                     | cfg_addr, cfg_wdata
//
// From input transaction to result: an input register, then one pass through
// the segment tables, the dominant pick and the smoothing adder into the result register.
// Unless stalled, one transaction is taken per cycle; the smoothing register is the
// only loop. Reset (rst_n low, synchronous) empties both stages, clears the smoothed value
// and loads the register defaults. A stalled output holds its result and the input stage,
// and in_tready stays high while either stage can still move.
`timescale 1ns / 1ps

module air_quality_index_tracker #(
  parameter int unsigned FRACTION_BITS = aqit_pkg::AQIT_FRAC_BITS_DEF,
  localparam int unsigned SMOOTH_W    = aqit_pkg::INDEX_W + FRACTION_BITS,
  localparam int unsigned OUT_PAY_W   = aqit_pkg::INDEX_W + SMOOTH_W + aqit_pkg::BAND_W,
  localparam int unsigned OUT_TDATA_W = ((OUT_PAY_W + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // eco2_ppm[15:0], tvoc_ppb[31:16], pm25_ug[43:32], pm10_ug[55:44], co_centippm[71:56]
  input  logic [71:0]                   in_tdata,
  // pm_ready[0]
  input  logic                          in_tuser,
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // dominant_index, smoothed_index_q8, quality_band, zero fill (lowest bit up)
  output logic [OUT_TDATA_W-1:0]        out_tdata,
  // dominant_pollutant[2:0]
  output logic [2:0]                    out_tuser,
  // configuration port
  input  logic                          cfg_we,
  input  logic [aqit_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [aqit_pkg::CFG_W-1:0]    cfg_wdata
);
  import aqit_pkg::*;

  // Configuration registers
  logic [CFG_W-1:0] smooth_floor_r;
  logic [CFG_W-1:0] band_limit_low_r;
  logic [CFG_W-1:0] band_limit_mid_r;
  logic [CFG_W-1:0] band_limit_high_r;

  // Input stage
  logic        s1_valid_r;
  logic [15:0] s1_eco2_r;
  logic [15:0] s1_tvoc_r;
  logic [11:0] s1_pm25_r;
  logic [11:0] s1_pm10_r;
  logic        s1_pm_ready_r;
  logic [15:0] s1_co_r;

  // Result stage and smoothing state
  logic                out_valid_r;
  pollutant_t          out_pol_r;
  logic [INDEX_W-1:0]  out_idx_r;
  logic [SMOOTH_W-1:0] out_smooth_r;
  logic [BAND_W-1:0]   out_band_r;
  logic [SMOOTH_W-1:0] smooth_r;

  // Pass logic
  logic                out_load;
  logic                in_load;
  logic [INDEX_W-1:0]  sub_s [5];
  pollutant_t          win_nxt;
  logic [INDEX_W-1:0]  best_nxt;
  logic [SMOOTH_W:0]   sum_s;
  logic [SMOOTH_W-1:0] avg_s;
  logic [SMOOTH_W-1:0] floor_q;
  logic [SMOOTH_W-1:0] smooth_nxt;
  logic [BAND_W-1:0]   band_nxt;

  // Handshake: result register frees when empty or taken, input stage when it moves on
  assign out_load  = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || out_load;
  assign in_load   = in_tvalid && in_tready;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_floor_r    <= SMOOTH_FLOOR_RST;
      band_limit_low_r  <= BAND_LIMIT_LOW_RST;
      band_limit_mid_r  <= BAND_LIMIT_MID_RST;
      band_limit_high_r <= BAND_LIMIT_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_SMOOTH_FLOOR:    smooth_floor_r    <= cfg_wdata;
        CFG_BAND_LIMIT_LOW:  band_limit_low_r  <= cfg_wdata;
        CFG_BAND_LIMIT_MID:  band_limit_mid_r  <= cfg_wdata;
        CFG_BAND_LIMIT_HIGH: band_limit_high_r <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_eco2_r     <= in_tdata[15:0];
      s1_tvoc_r     <= in_tdata[31:16];
      s1_pm25_r     <= in_tdata[43:32];
      s1_pm10_r     <= in_tdata[55:44];
      s1_co_r       <= in_tdata[71:56];
      s1_pm_ready_r <= in_tuser;
    end
  end

  // Map each reading to its sub-index; PM counts as zero until ready
  always_comb begin
    sub_s[0] = sub_eco2(s1_eco2_r);
    sub_s[1] = sub_tvoc(s1_tvoc_r);
    sub_s[2] = s1_pm_ready_r ? sub_pm25(s1_pm25_r) : '0;
    sub_s[3] = s1_pm_ready_r ? sub_pm10(s1_pm10_r) : '0;
    sub_s[4] = sub_co(s1_co_r);
  end

  // Pick the largest sub-index; the earlier pollutant keeps a tie
  always_comb begin
    win_nxt  = POL_ECO2;
    best_nxt = sub_s[0];
    if (best_nxt < sub_s[1]) begin
      win_nxt  = POL_TVOC;
      best_nxt = sub_s[1];
    end
    if (best_nxt < sub_s[2]) begin
      win_nxt  = POL_PM25;
      best_nxt = sub_s[2];
    end
    if (best_nxt < sub_s[3]) begin
      win_nxt  = POL_PM10;
      best_nxt = sub_s[3];
    end
    if (best_nxt < sub_s[4]) begin
      win_nxt  = POL_CO;
      best_nxt = sub_s[4];
    end
  end

  // Average with the previous value, truncate, then raise to the floor
  always_comb begin
    sum_s   = {1'b0, best_nxt, {FRACTION_BITS{1'b0}}} + {1'b0, smooth_r};
    avg_s   = sum_s[SMOOTH_W:1];
    floor_q = {smooth_floor_r, {FRACTION_BITS{1'b0}}};
    smooth_nxt = (avg_s < floor_q) ? floor_q : avg_s;
  end

  // Classify against the limits in order low, mid, high
  always_comb begin
    priority if (smooth_nxt < {band_limit_low_r, {FRACTION_BITS{1'b0}}}) begin
      band_nxt = BAND_GOOD;
    end else if (smooth_nxt < {band_limit_mid_r, {FRACTION_BITS{1'b0}}}) begin
      band_nxt = BAND_MODERATE;
    end else if (smooth_nxt < {band_limit_high_r, {FRACTION_BITS{1'b0}}}) begin
      band_nxt = BAND_POOR;
    end else begin
      band_nxt = BAND_BAD;
    end
  end

  // Advance the smoothing state and the result register together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      smooth_r    <= '0;
    end else begin
      if (out_load) begin
        smooth_r <= smooth_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_pol_r    <= win_nxt;
      out_idx_r    <= best_nxt;
      out_smooth_r <= smooth_nxt;
      out_band_r   <= band_nxt;
    end
  end

  // Drive the result channel
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_band_r, out_smooth_r, out_idx_r});
  assign out_tuser  = out_pol_r;

`ifndef NO_ASSERTIONS
  // A loaded result carries the smoothing state it leaves behind
  a_state_matches_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (smooth_r == out_smooth_r))
    else $error("smoothing state and result disagree");

  // A waiting input transaction is not dropped
  a_input_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !out_load) |=> s1_valid_r)
    else $error("input stage lost a transaction");

  // The dominant sub-index never leaves the index scale
  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_idx_r <= INDEX_MAX))
    else $error("dominant index above scale");
`endif

endmodule

>>> test/tb.sv
// Testbench for the air quality index tracker: random sensor sets checked against a scoreboard.
`timescale 1ns / 1ps

module tb;
  import aqit_pkg::*;

  localparam int unsigned FRAC_BITS      = AQIT_FRAC_BITS_DEF;
  localparam int unsigned SMOOTH_W       = INDEX_W + FRAC_BITS;
  localparam int unsigned PAY_W          = INDEX_W + SMOOTH_W + BAND_W;
  localparam int unsigned OUT_W          = ((PAY_W + 7) / 8) * 8;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASES         = 7;
  localparam int unsigned RANDOM_PER_PHASE = 105;

  typedef int unsigned edge_list_t [7];

  // Segment starts per pollutant, used to aim random readings at the knees
  localparam edge_list_t ECO2_EDGES = '{350, 885, 1334, 1766, 2552, 3852, 5000};
  localparam edge_list_t TVOC_EDGES = '{300, 500, 1000, 3000, 4000, 5000, 60000};
  localparam edge_list_t PM25_EDGES = '{13, 36, 56, 151, 251, 501, 4095};
  localparam edge_list_t PM10_EDGES = '{55, 155, 255, 355, 425, 604, 4095};
  localparam edge_list_t CO_EDGES   = '{450, 950, 1250, 1550, 3050, 5040, 65535};

  typedef struct {
    logic [15:0] eco2;
    logic [15:0] tvoc;
    logic [11:0] pm25;
    logic [11:0] pm10;
    logic        pm_ready;
    logic [15:0] co;
  } reading_t;

  typedef struct {
    pollutant_t            pollutant;
    logic [INDEX_W-1:0]    index;
    logic [SMOOTH_W-1:0]   smoothed;
    logic [BAND_W-1:0]     band;
  } aqi_report_t;

  // Scoreboard: predicts the report for each accepted sensor set and checks results in order
  class aqi_scoreboard;
    aqi_report_t         expected_reports[$];
    logic [SMOOTH_W-1:0] smoothed_acc;
    logic [CFG_W-1:0]    floor_units;
    logic [CFG_W-1:0]    limit_low;
    logic [CFG_W-1:0]    limit_mid;
    logic [CFG_W-1:0]    limit_high;
    int unsigned         mismatches;

    function new();
      smoothed_acc = '0;
      floor_units  = SMOOTH_FLOOR_RST;
      limit_low    = BAND_LIMIT_LOW_RST;
      limit_mid    = BAND_LIMIT_MID_RST;
      limit_high   = BAND_LIMIT_HIGH_RST;
      mismatches   = 0;
    endfunction

    function void set_reg(logic [CFG_AW-1:0] addr, logic [CFG_W-1:0] value);
      case (addr)
        CFG_SMOOTH_FLOOR:    floor_units = value;
        CFG_BAND_LIMIT_LOW:  limit_low   = value;
        CFG_BAND_LIMIT_MID:  limit_mid   = value;
        CFG_BAND_LIMIT_HIGH: limit_high  = value;
        default: ;
      endcase
    endfunction

    static function int unsigned grade_eco2(int unsigned e);
      if (e < 350) return 0;
      if (e <= 884) return ((e - 350) * 100) / 1052;
      if (e <= 1333) return (100 * e - 88498) / 898 + 51;
      if (e <= 1765) return (10 * e - 13335) / 85 + 101;
      if (e <= 2551) return (100 * e - 176576) / 1576 + 151;
      if (e <= 3851) return (100 * e - 255108) / 1308 + 201;
      if (e < 5000) return (100 * e - 385177) / 577 + 301;
      return 500;
    endfunction

    static function int unsigned grade_tvoc(int unsigned t);
      if (t < 300) return t / 6;
      if (t < 500) return (t - 300) / 4 + 50;
      if (t < 1000) return (t - 500) / 10 + 100;
      if (t < 3000) return (t - 1000) / 40 + 150;
      if (t < 4000) return (t - 3000) / 10 + 200;
      if (t < 5000) return (t - 4000) / 5 + 300;
      return 500;
    endfunction

    static function int unsigned grade_pm25(int unsigned p);
      if (p <= 12) return (100 * p) / 24;
      if (p <= 35) return (100 * p - 1210) / 47 + 51;
      if (p <= 55) return (10 * p - 355) / 4 + 101;
      if (p <= 150) return (10 * p - 555) / 19 + 151;
      if (p <= 250) return p + 50;
      if (p <= 500) return (4 * p - 1002) / 5 + 301;
      return 500;
    endfunction

    static function int unsigned grade_pm10(int unsigned q);
      if (q < 55) return (100 * q) / 108;
      if (q < 155) return (q - 55) / 2 + 51;
      if (q < 255) return (q - 155) / 2 + 101;
      if (q < 355) return (q - 255) / 2 + 151;
      if (q < 425) return (10 * (q - 355)) / 7 + 201;
      if (q < 604) return (10 * (q - 425)) / 9 + 301;
      return 500;
    endfunction

    static function int unsigned grade_co(int unsigned c);
      if (c < 450) return c / 9;
      if (c < 950) return (c - 450) / 10 + 51;
      if (c < 1250) return (c - 950) / 6 + 101;
      if (c < 1550) return (c - 1250) / 6 + 151;
      if (c < 3050) return (c - 1550) / 15 + 201;
      if (c < 5040) return (c - 3050) / 10 + 301;
      return 500;
    endfunction

    // Grade every pollutant, pick the leader, smooth and band
    function void note_reading(reading_t r);
      int unsigned grade [5];
      int unsigned k;
      int unsigned lead;
      int unsigned nxt;
      int unsigned floor_q;
      aqi_report_t rep;
      grade[0] = grade_eco2(r.eco2);
      grade[1] = grade_tvoc(r.tvoc);
      grade[2] = r.pm_ready ? grade_pm25(r.pm25) : 0;
      grade[3] = r.pm_ready ? grade_pm10(r.pm10) : 0;
      grade[4] = grade_co(r.co);
      // strict compare keeps the lower pollutant on a tie
      lead = 0;
      for (k = 1; k < 5; k++) begin
        if (grade[k] > grade[lead]) lead = k;
      end
      nxt = ((grade[lead] << FRAC_BITS) + int'(smoothed_acc)) >> 1;
      floor_q = int'(floor_units) << FRAC_BITS;
      if (nxt < floor_q) nxt = floor_q;
      smoothed_acc = SMOOTH_W'(nxt);
      rep.pollutant = pollutant_t'(lead[2:0]);
      rep.index     = INDEX_W'(grade[lead]);
      rep.smoothed  = SMOOTH_W'(nxt);
      if (nxt < (int'(limit_low) << FRAC_BITS)) rep.band = BAND_GOOD;
      else if (nxt < (int'(limit_mid) << FRAC_BITS)) rep.band = BAND_MODERATE;
      else if (nxt < (int'(limit_high) << FRAC_BITS)) rep.band = BAND_POOR;
      else rep.band = BAND_BAD;
      expected_reports.push_back(rep);
    endfunction

    function void log_mismatch(string what, longint unsigned want, longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void check_report(logic [2:0] pol, logic [OUT_W-1:0] data);
      aqi_report_t want;
      if (expected_reports.size() == 0) begin
        log_mismatch("unexpected result", 0, data);
        return;
      end
      want = expected_reports.pop_front();
      if (pol !== want.pollutant)
        log_mismatch("dominant_pollutant", want.pollutant, pol);
      if (data[INDEX_W-1:0] !== want.index)
        log_mismatch("dominant_index", want.index, data[INDEX_W-1:0]);
      if (data[INDEX_W +: SMOOTH_W] !== want.smoothed)
        log_mismatch("smoothed_index_q8", want.smoothed, data[INDEX_W +: SMOOTH_W]);
      if (data[INDEX_W+SMOOTH_W +: BAND_W] !== want.band)
        log_mismatch("quality_band", want.band, data[INDEX_W+SMOOTH_W +: BAND_W]);
      if (data[OUT_W-1:PAY_W] !== '0)
        log_mismatch("tdata fill", 0, data[OUT_W-1:PAY_W]);
    endfunction

    function int unsigned leftover();
      return expected_reports.size();
    endfunction
  endclass

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                in_tvalid  = 1'b0;
  logic                in_tready;
  logic [71:0]         in_tdata   = '0;
  logic                in_tuser   = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OUT_W-1:0]    out_tdata;
  logic [2:0]          out_tuser;
  logic                cfg_we     = 1'b0;
  logic [CFG_AW-1:0]   cfg_addr   = '0;
  logic [CFG_W-1:0]    cfg_wdata  = '0;

  aqi_scoreboard sb;
  bit            hold_req    = 1'b0;
  bit            rx_run_free = 1'b0;
  int unsigned   idle_run    = 0;

  air_quality_index_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Small values, values around a segment start, in-range values, or any bit pattern
  function automatic int unsigned pick_level(int unsigned top, int unsigned mask,
                                             edge_list_t edges);
    int unsigned sel;
    int unsigned v;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      v = $urandom_range(0, 40);
    end else if (sel < 5) begin
      v = edges[$urandom_range(0, 6)] + $urandom_range(0, 4);
      v = (v >= 2) ? v - 2 : 0;
    end else if (sel < 9) begin
      v = $urandom_range(0, top);
    end else begin
      v = $urandom;
    end
    return v & mask;
  endfunction

  function automatic reading_t random_reading();
    reading_t r;
    r.eco2     = 16'(pick_level(60000, 16'hFFFF, ECO2_EDGES));
    r.tvoc     = 16'(pick_level(60000, 16'hFFFF, TVOC_EDGES));
    r.pm25     = 12'(pick_level(4095, 12'hFFF, PM25_EDGES));
    r.pm10     = 12'(pick_level(4095, 12'hFFF, PM10_EDGES));
    r.pm_ready = ($urandom_range(0, 3) != 0);
    r.co       = 16'(pick_level(65535, 16'hFFFF, CO_EDGES));
    return r;
  endfunction

  function automatic reading_t make_reading(int unsigned e, int unsigned t, int unsigned p25,
                                            int unsigned p10, bit rdy, int unsigned c);
    reading_t r;
    r.eco2     = 16'(e);
    r.tvoc     = 16'(t);
    r.pm25     = 12'(p25);
    r.pm10     = 12'(p10);
    r.pm_ready = rdy;
    r.co       = 16'(c);
    return r;
  endfunction

  // Offer one sensor set and hold it until the block takes it
  task automatic offer_reading(input reading_t r);
    in_tvalid <= 1'b1;
    in_tdata  <= {r.co, r.pm10, r.pm25, r.tvoc, r.eco2};
    in_tuser  <= r.pm_ready;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_reading(r);
  endtask

  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    sb.set_reg(addr, value);
  endtask

  // Drain the pipeline, then load all four registers
  task automatic apply_settings(input logic [CFG_W-1:0] f, input logic [CFG_W-1:0] lo,
                                input logic [CFG_W-1:0] mid, input logic [CFG_W-1:0] hi);
    do @(posedge clk); while (sb.leftover() != 0);
    repeat (3) @(posedge clk);
    write_reg(CFG_SMOOTH_FLOOR, f);
    write_reg(CFG_BAND_LIMIT_LOW, lo);
    write_reg(CFG_BAND_LIMIT_MID, mid);
    write_reg(CFG_BAND_LIMIT_HIGH, hi);
    cfg_we <= 1'b0;
  endtask

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_report(out_tuser, out_tdata);
  end

  // Abort when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) idle_run = 0;
    else idle_run = idle_run + 1;
    if (idle_run >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, free-running stretches, and one long hold on request
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (!rx_run_free && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      if ($urandom_range(0, 149) == 0) rx_run_free = !rx_run_free;
    end
  end

  // Stimulus: directed sets, then random sets across several register settings
  initial begin
    reading_t         directed[$];
    int unsigned      phase;
    int unsigned      n;
    logic [CFG_W-1:0] f;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] mid;
    logic [CFG_W-1:0] hi;
    sb = new();

    // all zero, eCO2 knees and top
    directed.push_back(make_reading(0, 0, 0, 0, 0, 0));
    directed.push_back(make_reading(884, 0, 0, 0, 0, 0));
    directed.push_back(make_reading(885, 0, 0, 0, 0, 0));
    directed.push_back(make_reading(1765, 0, 0, 0, 0, 0));
    directed.push_back(make_reading(4999, 0, 0, 0, 0, 0));
    directed.push_back(make_reading(5000, 0, 0, 0, 0, 0));
    // TVOC around the moved boundary and past the top
    directed.push_back(make_reading(0, 2999, 0, 0, 0, 0));
    directed.push_back(make_reading(0, 3000, 0, 0, 0, 0));
    directed.push_back(make_reading(0, 4999, 0, 0, 0, 0));
    directed.push_back(make_reading(0, 60000, 0, 0, 0, 0));
    // PM2.5 knees and top
    directed.push_back(make_reading(0, 0, 12, 0, 1, 0));
    directed.push_back(make_reading(0, 0, 13, 0, 1, 0));
    directed.push_back(make_reading(0, 0, 500, 0, 1, 0));
    directed.push_back(make_reading(0, 0, 501, 0, 1, 0));
    // PM not ready masks even full-scale readings
    directed.push_back(make_reading(0, 0, 4095, 4095, 0, 0));
    // PM10 knees and top
    directed.push_back(make_reading(0, 0, 0, 424, 1, 0));
    directed.push_back(make_reading(0, 0, 0, 603, 1, 0));
    directed.push_back(make_reading(0, 0, 0, 604, 1, 0));
    // CO knees and saturated reading
    directed.push_back(make_reading(0, 0, 0, 0, 0, 449));
    directed.push_back(make_reading(0, 0, 0, 0, 0, 5039));
    directed.push_back(make_reading(0, 0, 0, 0, 0, 65535));
    // ties go to the lower pollutant
    directed.push_back(make_reading(0, 294, 0, 0, 0, 441));
    directed.push_back(make_reading(0, 0, 4095, 4095, 1, 0));
    directed.push_back(make_reading(0, 0, 0, 4095, 1, 65535));
    directed.push_back(make_reading(65535, 65535, 4095, 4095, 1, 65535));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          f = SMOOTH_FLOOR_RST; lo = BAND_LIMIT_LOW_RST;
          mid = BAND_LIMIT_MID_RST; hi = BAND_LIMIT_HIGH_RST;
        end
        1: begin
          f = '0; lo = '0; mid = '0; hi = '0;
        end
        2: begin
          f = INDEX_MAX; lo = INDEX_MAX; mid = INDEX_MAX; hi = INDEX_MAX;
        end
        3: begin
          // limits out of order
          f = '0; lo = 9'd300; mid = 9'd100; hi = 9'd200;
        end
        4: begin
          f = CFG_W'($urandom_range(0, 60));
          lo = CFG_W'($urandom_range(0, 150));
          mid = lo + CFG_W'($urandom_range(0, 150));
          hi = mid + CFG_W'($urandom_range(0, 200));
        end
        5: begin
          f = '0; lo = 9'd100; mid = 9'd200; hi = 9'd400;
        end
        default: begin
          f = CFG_W'($urandom_range(0, 500));
          lo = CFG_W'($urandom_range(0, 500));
          mid = CFG_W'($urandom_range(0, 500));
          hi = CFG_W'($urandom_range(0, 500));
        end
      endcase
      apply_settings(f, lo, mid, hi);

      if (phase == 0) begin
        foreach (directed[i]) offer_reading(directed[i]);
      end
      // let the result side back up into the input
      if (phase == 5) hold_req = 1'b1;

      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        offer_reading(random_reading());
        if (phase == 4 && n == 50) begin
          // pause the source until the pipeline is empty
          in_tvalid <= 1'b0;
          do @(posedge clk); while (sb.leftover() != 0);
        end else if (phase != 2 && $urandom_range(0, 2) == 0) begin
          in_tvalid <= 1'b0;
          repeat (pick_gap()) @(posedge clk);
        end
      end
      in_tvalid <= 1'b0;
    end

    // wait for the last results, then let the pipeline settle
    do @(posedge clk); while (sb.leftover() != 0);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.leftover() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/aqit_pkg.sv
rtl/air_quality_index_tracker.sv
test/tb.sv
